@@ sv/dvp_pkg.sv @@
// Shared types and constants for the drum voice pool engine.
package dvp_pkg;

  localparam int VOICE_SLOTS = 64;
  localparam int ADDR_BITS   = 24;
  localparam int IDX_W       = $clog2(VOICE_SLOTS);
  localparam int CNT_W       = $clog2(VOICE_SLOTS + 1);

  localparam logic [23:0] ADDR_MASK = 24'((64'(1) << ADDR_BITS) - 64'(1));

  localparam logic CMD_TRIGGER = 1'b0;
  localparam logic CMD_TICK    = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [23:0] sample_start;
    logic [23:0] sample_len;
    logic [3:0]  out_channel;
    logic [3:0]  choke_group;
    logic [6:0]  velocity;
    logic        stereo;
    logic        apply_choke;
  } in_item_t;

  typedef struct packed {
    logic        active;
    logic [23:0] fetch_addr;
    logic [3:0]  mix_channel;
    logic [6:0]  gain_code;
    logic        two_plane;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [23:0] start;
    logic [23:0] length;
    logic [23:0] position;
    logic [3:0]  channel;
    logic [3:0]  choke;
    logic [6:0]  velocity;
    logic        stereo;
  } voice_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

@@ sv/dvp_cell.sv @@
// One voice slot of the pool chain: loads from its upper neighbor or a write.
module dvp_cell (
  input  logic               clk_i,
  input  dvp_pkg::cell_ctl_t ctl_i,
  input  dvp_pkg::voice_t    nxt_i,
  input  dvp_pkg::voice_t    wr_data_i,
  output dvp_pkg::voice_t    voice_o
);

  dvp_pkg::voice_t voice_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr) begin
      voice_q <= wr_data_i;
    end else if (ctl_i.shift) begin
      voice_q <= nxt_i;
    end
  end

  assign voice_o = voice_q;

endmodule

@@ sv/drum_voice_pool_engine_unit.sv @@
// Top level of the drum voice pool engine: controller and chain of voice cells.
//
// Input channel (in_valid_i / in_stall_o / in_data_i) takes trigger and tick
// transactions; output channel (out_valid_o / out_stall_i / out_data_o) returns
// fetch results. A transaction is accepted while its valid is high and its
// stall is low.
// Voices sit in a chain of VOICE_SLOTS cells, oldest at cell 0. A tick walks
// the pool by popping the head at each step and writing survivors back
// behind the unprocessed voices; it emits one result per voice (one
// inactive result when the pool is empty).
// A trigger with choke removal walks the pool the same way without results,
// then appends the new voice; a plain trigger only appends.
// The first result of a tick is registered in out_q after the walk state is
// entered, once the output is free. A stalled output holds its result and
// freezes the tick walk; a new input is taken only while the controller is
// idle, even if a result still waits.
// Reset empties the pool at once; voice storage is not cleared.
module drum_voice_pool_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dvp_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dvp_pkg::out_item_t out_data_o
);

  typedef enum logic [1:0] {S_IDLE, S_PASS, S_APPEND, S_EMPTY} state_e;

  state_e                     state_q;
  dvp_pkg::in_item_t          item_q;
  logic [dvp_pkg::CNT_W-1:0]  count_q, r_q, w_q;
  logic                       out_valid_q;
  dvp_pkg::out_item_t         out_q;

  dvp_pkg::voice_t            voices [dvp_pkg::VOICE_SLOTS];
  dvp_pkg::voice_t            head, wr_data;
  dvp_pkg::cell_ctl_t         ctl [dvp_pkg::VOICE_SLOTS];
  logic                       shift, wr;
  logic [dvp_pkg::IDX_W-1:0]  wr_idx;
  logic [dvp_pkg::CNT_W-1:0]  wr_pos;
  logic                       out_free, is_tick, step, keep;
  logic [23:0]                pos_inc;
  logic                       full;
  logic                       out_load;

  assign head     = voices[0];
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_tick  = item_q.cmd == dvp_pkg::CMD_TICK;
  assign pos_inc  = head.position + 24'd1;
  assign keep     = is_tick ? (pos_inc < head.length) : (head.choke != item_q.choke_group);
  assign step     = (state_q == S_PASS) && (!is_tick || out_free);
  assign full     = count_q == dvp_pkg::CNT_W'(dvp_pkg::VOICE_SLOTS);
  assign wr_pos   = r_q - dvp_pkg::CNT_W'(1) + w_q;
  assign out_load = (step && is_tick) || (state_q == S_EMPTY && out_free);

  always_comb begin
    shift   = 1'b0;
    wr      = 1'b0;
    wr_idx  = wr_pos[dvp_pkg::IDX_W-1:0];
    wr_data = head;
    case (state_q)
      S_PASS: begin
        shift = step;
        wr    = step && keep;
        if (is_tick) begin
          wr_data.position = pos_inc;
        end
      end
      S_APPEND: begin
        wr                = item_q.sample_len != 24'd0;
        shift             = wr && full;
        wr_idx            = full ? dvp_pkg::IDX_W'(dvp_pkg::VOICE_SLOTS - 1)
                                 : count_q[dvp_pkg::IDX_W-1:0];
        wr_data.start     = item_q.sample_start;
        wr_data.length    = item_q.sample_len;
        wr_data.position  = 24'd0;
        wr_data.channel   = item_q.out_channel;
        wr_data.choke     = item_q.choke_group;
        wr_data.velocity  = item_q.velocity;
        wr_data.stereo    = item_q.stereo;
      end
      default: begin
      end
    endcase
  end

  for (genvar g = 0; g < dvp_pkg::VOICE_SLOTS; g++) begin : g_cell
    dvp_pkg::voice_t nxt;
    if (g == dvp_pkg::VOICE_SLOTS - 1) begin : g_top
      assign nxt = voices[g];
    end else begin : g_mid
      assign nxt = voices[g+1];
    end
    assign ctl[g].shift = shift;
    assign ctl[g].wr    = wr && (wr_idx == dvp_pkg::IDX_W'(g));
    dvp_cell u_cell (
      .clk_i     (clk_i),
      .ctl_i     (ctl[g]),
      .nxt_i     (nxt),
      .wr_data_i (wr_data),
      .voice_o   (voices[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      count_q     <= '0;
      r_q         <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            item_q <= in_data_i;
            r_q    <= count_q;
            w_q    <= '0;
            if (in_data_i.cmd == dvp_pkg::CMD_TICK) begin
              state_q <= (count_q == '0) ? S_EMPTY : S_PASS;
            end else if (in_data_i.apply_choke && in_data_i.choke_group != 4'd0 &&
                         count_q != '0) begin
              state_q <= S_PASS;
            end else begin
              state_q <= S_APPEND;
            end
          end
        end
        S_PASS: begin
          if (step) begin
            r_q <= r_q - dvp_pkg::CNT_W'(1);
            w_q <= w_q + (keep ? dvp_pkg::CNT_W'(1) : '0);
            if (is_tick) begin
              out_q.active      <= 1'b1;
              out_q.fetch_addr  <= (head.start + head.position) & dvp_pkg::ADDR_MASK;
              out_q.mix_channel <= head.channel;
              out_q.gain_code   <= head.velocity;
              out_q.two_plane   <= head.stereo;
              out_q.last        <= r_q == dvp_pkg::CNT_W'(1);
            end
            if (r_q == dvp_pkg::CNT_W'(1)) begin
              count_q <= w_q + (keep ? dvp_pkg::CNT_W'(1) : '0);
              state_q <= is_tick ? S_IDLE : S_APPEND;
            end
          end
        end
        S_APPEND: begin
          if (item_q.sample_len != 24'd0 && !full) begin
            count_q <= count_q + dvp_pkg::CNT_W'(1);
          end
          state_q <= S_IDLE;
        end
        S_EMPTY: begin
          if (out_free) begin
            out_q   <= '{active: 1'b0, fetch_addr: 24'd0, mix_channel: 4'd0,
                         gain_code: 7'd0, two_plane: 1'b0, last: 1'b1};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= dvp_pkg::CNT_W'(dvp_pkg::VOICE_SLOTS))
    else $error("voice count above pool size");

  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_PASS |-> (r_q != '0 && r_q + w_q <= count_q))
    else $error("walk pointers out of range");

  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.active |-> out_q.last)
    else $error("inactive result without last");

endmodule

@@ tb/sv/dvp_checker.sv @@
// Checker for the drum voice pool engine: predicts fetch results and compares them.
module dvp_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  dvp_pkg::in_item_t  in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  dvp_pkg::out_item_t out_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 fetch_seen_o
);

  dvp_pkg::voice_t    pool_q[$];
  dvp_pkg::out_item_t fetch_expect_q[$];

  task automatic pool_apply(input dvp_pkg::in_item_t it);
    dvp_pkg::voice_t    v;
    dvp_pkg::voice_t    kept[$];
    dvp_pkg::out_item_t r;
    if (it.cmd == dvp_pkg::CMD_TRIGGER) begin
      if (it.apply_choke && it.choke_group != 4'd0) begin
        kept = {};
        foreach (pool_q[i]) if (pool_q[i].choke != it.choke_group) kept = {kept, pool_q[i]};
        pool_q = kept;
      end
      if (it.sample_len != 24'd0) begin
        if (pool_q.size() >= dvp_pkg::VOICE_SLOTS) void'(pool_q.pop_front());
        v.start    = it.sample_start;
        v.length   = it.sample_len;
        v.position = 24'd0;
        v.channel  = it.out_channel;
        v.choke    = it.choke_group;
        v.velocity = it.velocity;
        v.stereo   = it.stereo;
        pool_q = {pool_q, v};
      end
    end else if (pool_q.size() == 0) begin
      r = '0;
      r.last = 1'b1;
      fetch_expect_q = {fetch_expect_q, r};
    end else begin
      kept = {};
      foreach (pool_q[i]) begin
        r.active      = 1'b1;
        r.fetch_addr  = (pool_q[i].start + pool_q[i].position) & dvp_pkg::ADDR_MASK;
        r.mix_channel = pool_q[i].channel;
        r.gain_code   = pool_q[i].velocity;
        r.two_plane   = pool_q[i].stereo;
        r.last        = (i == pool_q.size() - 1);
        fetch_expect_q = {fetch_expect_q, r};
        v = pool_q[i];
        v.position = v.position + 24'd1;
        if (v.position < v.length) kept = {kept, v};
      end
      pool_q = kept;
    end
  endtask

  always @(posedge clk_i) begin
    dvp_pkg::out_item_t e;
    if (!rst_ni) begin
      fail_count_o = 0;
      pending_o    <= 0;
      fetch_seen_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        fetch_seen_o <= fetch_seen_o + 1;
        if (fetch_expect_q.size() == 0) begin
          fail_count_o = fail_count_o + 1;
          if (fail_count_o <= 10) $display("unexpected fetch %h", out_data_i);
        end else begin
          e = fetch_expect_q.pop_front();
          if (e.active !== out_data_i.active || e.fetch_addr !== out_data_i.fetch_addr ||
              e.mix_channel !== out_data_i.mix_channel ||
              e.gain_code !== out_data_i.gain_code ||
              e.two_plane !== out_data_i.two_plane || e.last !== out_data_i.last) begin
            fail_count_o = fail_count_o + 1;
            if (fail_count_o <= 10)
              $display("fetch mismatch: expected %h actual %h", e, out_data_i);
          end
        end
      end
      if (in_valid_i && !in_stall_i) pool_apply(in_data_i);
      pending_o <= fetch_expect_q.size();
    end
  end
endmodule

@@ tb/sv/testbench.sv @@
// Testbench top: drives trigger and tick transactions and reports the verdict.
module testbench;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  dvp_pkg::in_item_t  in_data_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  dvp_pkg::out_item_t out_data_o;
  int                 fail_count, pending, fetch_seen;
  int                 send_idle_pct = 11, recv_idle_pct = 72;
  bit                 recv_hold = 1'b0;
  int                 items_sent = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  drum_voice_pool_engine_unit dut (.*);

  dvp_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .in_data_i,
    .out_valid_i(out_valid_o), .out_stall_i, .out_data_i(out_data_o),
    .fail_count_o(fail_count), .pending_o(pending), .fetch_seen_o(fetch_seen)
  );

  always @(posedge clk_i) begin
    out_stall_i <= recv_hold || ($urandom_range(99) < recv_idle_pct);
  end

  function automatic dvp_pkg::in_item_t trigger_item(input logic [23:0] s,
                                                     input logic [23:0] l,
                                                     input logic [3:0] ch,
                                                     input logic [3:0] ck,
                                                     input logic [6:0] vel,
                                                     input logic st,
                                                     input logic ap);
    dvp_pkg::in_item_t it;
    it = '{dvp_pkg::CMD_TRIGGER, s, l, ch, ck, vel, st, ap};
    return it;
  endfunction

  function automatic dvp_pkg::in_item_t random_item();
    dvp_pkg::in_item_t it;
    logic [95:0]       raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[$bits(dvp_pkg::in_item_t)-1:0];
    it.cmd = ($urandom_range(99) < 45) ? dvp_pkg::CMD_TICK : dvp_pkg::CMD_TRIGGER;
    if (it.cmd == dvp_pkg::CMD_TRIGGER) begin
      case ($urandom_range(9))
        0:       it.sample_len = 24'd0;
        1:       it.sample_len = 24'hFFFFFF;
        2, 3, 4: it.sample_len = 24'($urandom_range(1, 3));
        default: it.sample_len = 24'($urandom_range(1, 40));
      endcase
      it.choke_group = 4'($urandom_range(3));
      if ($urandom_range(7) == 0) it.choke_group = 4'($urandom_range(15));
    end
    return it;
  endfunction

  task automatic send_item(input dvp_pkg::in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  initial begin
    dvp_pkg::in_item_t it;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty tick, field extremes, chokes, zero length
    it = '0;
    it.cmd = dvp_pkg::CMD_TICK;
    send_item(it);
    send_item(trigger_item(24'hFFFFFF, 24'hFFFFFF, 4'hF, 4'hF, 7'h7F, 1'b1, 1'b1));
    send_item(trigger_item(24'h000000, 24'h000001, 4'h0, 4'h0, 7'h00, 1'b0, 1'b0));
    send_item(trigger_item(24'hFFFFFE, 24'd3, 4'd14, 4'd2, 7'd1, 1'b1, 1'b0));
    send_item(trigger_item(24'h123456, 24'd0, 4'd5, 4'd2, 7'd64, 1'b0, 1'b0));
    send_item(it);
    send_item(it);
    send_item(trigger_item(24'h00ABCD, 24'd5, 4'd3, 4'd2, 7'd9, 1'b0, 1'b1));
    send_item(trigger_item(24'h000100, 24'd0, 4'd1, 4'hF, 7'd2, 1'b1, 1'b1));
    send_item(trigger_item(24'h000200, 24'd2, 4'd1, 4'd0, 7'd3, 1'b0, 1'b1));
    send_item(it);
    for (int i = 0; i < 70; i++)
      send_item(trigger_item(24'($urandom), 24'd2 + i[23:0], 4'($urandom_range(15)),
                             4'($urandom_range(15)), 7'($urandom_range(127)),
                             1'($urandom), 1'b0));
    send_item(it);
    send_item(it);
    // full pool with receiver held off: block fills and stalls input
    recv_hold = 1'b1;
    fork
      begin repeat (400) @(posedge clk_i); recv_hold = 1'b0; end
      begin send_item(it); send_item(it); send_item(it); end
    join
    wait_drained();
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 11 : (phase == 1) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 72 : (phase == 1) ? 11 : 0;
      for (int i = 0; i < 100; i++) send_item(random_item());
      wait_drained();
    end
    wait_drained();
    $display("Sent %0d transactions, checked %0d fetch results incl. choke, steal, wrap.",
             items_sent, fetch_seen);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
